### hdl/pdp_pkg.sv
// Shared types and constants for the depth point projector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pdp_pkg;

    // Field widths of the pixel and point beats
    localparam int DEPTH_W   = 16;
    localparam int COORD_W   = 11;
    localparam int VIEW_W    = 10;
    localparam int CHAN_W    = 8;
    localparam int PARAM_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd5;

    // View selector codes
    localparam logic [1:0] VIEW_TOP   = 2'd0;
    localparam logic [1:0] VIEW_SIDE  = 2'd1;
    localparam logic [1:0] VIEW_FRONT = 2'd2;

    // Pass codes
    localparam logic FUNC_STATS   = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    // Depth limit (10 m in Q8.8) and the depth-offset divisor 256 * 10
    localparam int JOB_DEPTH_W = 12;
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'd2560;
    localparam int ZDIV = 2560;

    // Divider sizing
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 28;

    // Reset values of the registers
    localparam logic [1:0]         RST_VIEW_SELECT = VIEW_FRONT;
    localparam logic [VIEW_W-1:0]  RST_VIEW_SIZE   = 10'd700;
    localparam logic [PARAM_W-1:0] RST_FOCAL       = 16'd8400;
    localparam logic [PARAM_W-1:0] RST_CENTER_X    = 16'd5120;
    localparam logic [PARAM_W-1:0] RST_CENTER_Y    = 16'd3840;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic               func;
        logic               frame_start;
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [DEPTH_W-1:0] depth_value;
    } pixel_t;

    typedef struct packed {
        logic [VIEW_W-1:0] view_row;
        logic [VIEW_W-1:0] view_col;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } point_t;

    typedef struct packed {
        logic [1:0]         view_select;
        logic [VIEW_W-1:0]  view_size;
        logic [PARAM_W-1:0] focal_x;
        logic [PARAM_W-1:0] focal_y;
        logic [PARAM_W-1:0] center_x;
        logic [PARAM_W-1:0] center_y;
    } cfg_t;

    // One projection job from the front to the back
    typedef struct packed {
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        logic [JOB_DEPTH_W-1:0] depth;
        logic [DEPTH_W-1:0]     min_depth;
        logic [DEPTH_W-1:0]     max_depth;
    } job_t;

    typedef enum logic [1:0] {
        OP_Z,
        OP_X,
        OP_Y
    } op_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PREP,
        B_MUL1,
        B_MUL2,
        B_DIV,
        B_POS,
        B_JET1,
        B_JET2,
        B_JDIV,
        B_EMIT
    } back_state_t;

endpackage

### hdl/pdp_queue.sv
// Short job queue between the front and back of the projector.
// Depends on pdp_pkg for the job type.
`timescale 1ns / 1ps

module pdp_queue
    import pdp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### hdl/pdp_front.sv
// Front end: accepts pixel beats, keeps frame min and max, filters pixels.
// Depends on pdp_pkg; feeds jobs into pdp_queue.
`timescale 1ns / 1ps

module pdp_front
    import pdp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pixel_t pixel,
    output logic   full,
    input  logic   q_full,
    output logic   enq,
    output job_t   job
);

    logic [DEPTH_W-1:0] min_reg, min_next;
    logic [DEPTH_W-1:0] max_reg, max_next;
    logic               accept;
    logic               skip;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Drop odd positions, zero depth and depth beyond the limit
    assign skip = pixel.pixel_col[0] || pixel.pixel_row[0] ||
                  (pixel.depth_value == '0) || (pixel.depth_value > DEPTH_LIMIT);

    assign enq = accept && (pixel.func == FUNC_PROJECT) && !skip;

    always_comb
    begin
        job.col       = pixel.pixel_col;
        job.row       = pixel.pixel_row;
        job.depth     = pixel.depth_value[JOB_DEPTH_W-1:0];
        job.min_depth = min_reg;
        job.max_depth = max_reg;
    end

    // Track frame statistics
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept && (pixel.func == FUNC_STATS))
        begin
            if (pixel.frame_start)
            begin
                min_next = pixel.depth_value;
                max_next = pixel.depth_value;
            end
            else
            begin
                if (pixel.depth_value < min_reg)
                begin
                    min_next = pixel.depth_value;
                end
                if (pixel.depth_value > max_reg)
                begin
                    max_next = pixel.depth_value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

### hdl/pdp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pdp_pkg for default widths.
`timescale 1ns / 1ps

module pdp_div
    import pdp_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    assign done = done_reg;
    assign quo  = quo_reg;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // Load the operands on start, else shift in one numerator bit and subtract when it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

### hdl/pdp_back.sv
// Back end: projects queued jobs, checks view bounds, colors and emits points.
// Depends on pdp_pkg and the shared divider pdp_div.
`timescale 1ns / 1ps

module pdp_back
    import pdp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_empty,
    input  job_t   q_job,
    output logic   q_pop,
    output logic   empty,
    input  logic   pop,
    output point_t point
);

    localparam int RES_W = DIV_NUM_W + 2;
    localparam int JN_W  = DEPTH_W + 1;

    // (2^18 + 1) / 5: exact floor(y / 5) for y below 2^18
    localparam logic [15:0] ZDIV5_RECIP = 16'd52429;

    back_state_t state_reg, state_next;

    job_t                    job_reg, job_next;
    logic                    step_reg, step_next;
    logic                    sign_reg, sign_next;
    logic [PARAM_W-1:0]      mag_reg, mag_next;
    logic [27:0]             prod_reg, prod_next;
    logic signed [RES_W-1:0] res0_reg, res0_next;
    logic signed [RES_W-1:0] res1_reg, res1_next;
    logic [VIEW_W-1:0]       row_reg, row_next;
    logic [VIEW_W-1:0]       col_reg, col_next;
    logic [JN_W-1:0]         jn_reg, jn_next;
    logic [JN_W-1:0]         jd_reg, jd_next;
    logic [1:0]              jcase_reg, jcase_next;
    logic [CHAN_W-1:0]       blue_reg, blue_next;
    logic [CHAN_W-1:0]       green_reg, green_next;
    logic [CHAN_W-1:0]       red_reg, red_next;
    point_t                  out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    op_t                     cur_op;
    logic                    focal_bad;
    logic                    slot_free;
    logic signed [17:0]      diff;
    logic [PARAM_W-1:0]      fsel;
    logic [19:0]             fscaled;
    logic signed [RES_W-1:0] qres;
    logic signed [RES_W-1:0] center;
    logic signed [RES_W-1:0] size_ext;
    logic signed [RES_W-1:0] prow;
    logic signed [RES_W-1:0] pcol;
    logic                    in_view;
    logic [28:0]             zprod;
    logic signed [RES_W-1:0] zoff;
    logic signed [17:0]      jnum;
    logic signed [17:0]      jden;
    logic signed [17:0]      jnum_n;
    logic signed [17:0]      jden_n;
    logic [18:0]             n4;
    logic [18:0]             d2;
    logic [18:0]             d3;
    logic [18:0]             d4;
    logic [18:0]             jx;
    logic [26:0]             jscaled;

    pdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign empty     = !out_valid_reg;
    assign point     = out_reg;
    assign slot_free = !out_valid_reg || pop;

    // Pick the quantity for this step of the view
    always_comb
    begin
        case (cfg.view_select)
            VIEW_TOP:  cur_op = step_reg ? OP_X : OP_Z;
            VIEW_SIDE: cur_op = step_reg ? OP_Z : OP_Y;
            default:   cur_op = step_reg ? OP_X : OP_Y;
        endcase
    end

    always_comb
    begin
        case (cfg.view_select)
            VIEW_TOP:   focal_bad = (cfg.focal_x == '0);
            VIEW_SIDE:  focal_bad = (cfg.focal_y == '0);
            VIEW_FRONT: focal_bad = (cfg.focal_x == '0) || (cfg.focal_y == '0);
            default:    focal_bad = 1'b1;
        endcase
    end

    // Lateral offset numerator terms and denominator 256 * f * scale
    always_comb
    begin
        if (cur_op == OP_X)
        begin
            diff = $signed({3'b0, job_reg.col, 4'b0}) - $signed({2'b0, cfg.center_x});
            fsel = cfg.focal_x;
        end
        else
        begin
            diff = $signed({3'b0, job_reg.row, 4'b0}) - $signed({2'b0, cfg.center_y});
            fsel = cfg.focal_y;
        end
        if (cfg.view_select == VIEW_FRONT)
        begin
            fscaled = {2'b0, fsel, 2'b0} + {4'b0, fsel};
        end
        else
        begin
            fscaled = {1'b0, fsel, 3'b0} + {3'b0, fsel, 1'b0};
        end
    end

    // Depth offset: floor(d * v / 2560) as floor((d * v >> 9) / 5) by reciprocal
    always_comb
    begin
        zprod = prod_reg[21:9] * ZDIV5_RECIP;
        zoff  = $signed({{(RES_W-VIEW_W-1){1'b0}}, zprod[28:18]});
    end

    // Signed quotient and view position
    always_comb
    begin
        qres     = $signed({2'b0, div_quo});
        if (sign_reg)
        begin
            qres = -$signed({2'b0, div_quo});
        end
        center   = $signed({{(RES_W-VIEW_W+1){1'b0}}, cfg.view_size[VIEW_W-1:1]});
        size_ext = $signed({{(RES_W-VIEW_W){1'b0}}, cfg.view_size});
        prow     = (cfg.view_select == VIEW_SIDE) ? center - res0_reg : center + res0_reg;
        pcol     = center + res1_reg;
        in_view  = !prow[RES_W-1] && (prow < size_ext) && !pcol[RES_W-1] && (pcol < size_ext);
    end

    // Normalize the color ratio terms
    always_comb
    begin
        jnum   = $signed({6'b0, job_reg.depth}) - $signed({2'b0, job_reg.min_depth});
        jden   = $signed({2'b0, job_reg.max_depth}) - $signed({2'b0, job_reg.min_depth});
        jnum_n = jnum;
        jden_n = jden;
        if (jden < 0)
        begin
            jnum_n = -jnum;
            jden_n = -jden;
        end
        if (jnum_n < 0)
        begin
            jnum_n = '0;
        end
        else if (jnum_n > jden_n)
        begin
            jnum_n = jden_n;
        end
    end

    // Jet band terms
    always_comb
    begin
        n4 = {jn_reg, 2'b0};
        d2 = {1'b0, jd_reg, 1'b0};
        d4 = {jd_reg, 2'b0};
        d3 = {1'b0, jd_reg, 1'b0} + {2'b0, jd_reg};
        if (n4 < {2'b0, jd_reg})
        begin
            jcase_next = 2'd0;
            jx         = n4;
        end
        else if ({1'b0, jn_reg, 1'b0} < {2'b0, jd_reg})
        begin
            jcase_next = 2'd1;
            jx         = d2 - n4;
        end
        else if (n4 < d3)
        begin
            jcase_next = 2'd2;
            jx         = n4 - d2;
        end
        else
        begin
            jcase_next = 2'd3;
            jx         = d4 - n4;
        end
        jscaled = {jx, 8'b0} - {8'b0, jx};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && !focal_bad)
                begin
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                state_next = (cur_op == OP_Z) ? B_MUL2 : B_MUL1;
            end
            B_MUL1:
            begin
                state_next = B_MUL2;
            end
            B_MUL2:
            begin
                if (cur_op == OP_Z)
                begin
                    state_next = step_reg ? B_POS : B_PREP;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    state_next = step_reg ? B_POS : B_PREP;
                end
            end
            B_POS:
            begin
                state_next = in_view ? B_JET1 : B_IDLE;
            end
            B_JET1:
            begin
                state_next = (jden == 0) ? B_EMIT : B_JET2;
            end
            B_JET2:
            begin
                state_next = B_JDIV;
            end
            B_JDIV:
            begin
                if (div_done)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath updates and control outputs
    always_comb
    begin
        job_next       = job_reg;
        step_next      = step_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        jn_next        = jn_reg;
        jd_next        = jd_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        case (state_reg)
            B_IDLE:
            begin
                // Take the next job; drop it when the view cannot be formed
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    step_next = 1'b0;
                end
            end
            B_PREP:
            begin
                if (cur_op == OP_Z)
                begin
                    sign_next = 1'b0;
                    prod_next = 28'(job_reg.depth) * 28'(cfg.view_size);
                end
                else
                begin
                    sign_next = diff[17];
                    mag_next  = diff[17] ? PARAM_W'(-diff) : diff[PARAM_W-1:0];
                end
            end
            B_MUL1:
            begin
                prod_next = mag_reg * job_reg.depth;
            end
            B_MUL2:
            begin
                if (cur_op == OP_Z)
                begin
                    if (step_reg)
                    begin
                        res1_next = zoff;
                    end
                    else
                    begin
                        res0_next = zoff;
                        step_next = 1'b1;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    div_num   = prod_reg * cfg.view_size;
                    div_den   = {fscaled, 8'b0};
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    if (step_reg)
                    begin
                        res1_next = qres;
                    end
                    else
                    begin
                        res0_next = qres;
                        step_next = 1'b1;
                    end
                end
            end
            B_POS:
            begin
                row_next = prow[VIEW_W-1:0];
                col_next = pcol[VIEW_W-1:0];
            end
            B_JET1:
            begin
                jn_next = jnum_n[JN_W-1:0];
                jd_next = jden_n[JN_W-1:0];
                // Flat frame: pure red
                blue_next  = '0;
                green_next = '0;
                red_next   = '1;
            end
            B_JET2:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(jscaled);
                div_den   = DIV_DEN_W'(jd_reg);
                case (jcase_next)
                    2'd0:
                    begin
                        blue_next = '1;
                        red_next  = '0;
                    end
                    2'd1:
                    begin
                        green_next = '1;
                        red_next   = '0;
                    end
                    2'd2:
                    begin
                        blue_next  = '0;
                        green_next = '1;
                    end
                    default:
                    begin
                        blue_next = '0;
                        red_next  = '1;
                    end
                endcase
            end
            B_JDIV:
            begin
                if (div_done)
                begin
                    case (jcase_reg)
                        2'd0:    green_next = div_quo[CHAN_W-1:0];
                        2'd1:    blue_next  = div_quo[CHAN_W-1:0];
                        2'd2:    red_next   = div_quo[CHAN_W-1:0];
                        default: green_next = div_quo[CHAN_W-1:0];
                    endcase
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_next.view_row = row_reg;
                    out_next.view_col = col_reg;
                    out_next.blue     = blue_reg;
                    out_next.green    = green_reg;
                    out_next.red      = red_reg;
                    out_valid_next    = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Register the datapath; hold the band choice made while the division starts
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        step_reg  <= step_next;
        sign_reg  <= sign_next;
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        res0_reg  <= res0_next;
        res1_reg  <= res1_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        jn_reg    <= jn_next;
        jd_reg    <= jd_next;
        blue_reg  <= blue_next;
        green_reg <= green_next;
        red_reg   <= red_next;
        out_reg   <= out_next;
        if (state_reg == B_JET2)
        begin
            jcase_reg <= jcase_next;
        end
    end

endmodule

### hdl/depth_point_projector_jet.sv
// Usage
//   Pixel beats enter on a queue-style port: a beat is taken at a clock edge
//   with push high and full low. Statistics beats (func 0) update the frame
//   minimum and maximum depth; projection beats (func 1) are filtered and
//   queued for the back end, which back-projects them and emits at most one
//   point beat each. Points leave on a queue-style port: the oldest point is
//   on point while empty is low and is taken when pop is high.
//   Configuration registers are written through cfg_wr_en, cfg_index and
//   cfg_data; the user must write them only while the block is idle, and
//   the block itself does not enforce it.
//   A lateral offset takes one bit-serial division, the depth offset a
//   reciprocal multiply, and the color one more division; a flat frame
//   skips the color division. Four jobs can wait in the queue; full rises
//   when it holds four.
//   Reset clears the queue, the output register, the frame statistics
//   (minimum all ones, maximum zero) and loads the register reset values.
//   When the receiver stalls, the finished point holds in the output register
//   and the back end waits with the next point; the queue keeps filling.
// Depends on pdp_pkg, pdp_front, pdp_queue, pdp_back.
`timescale 1ns / 1ps

module depth_point_projector_jet
    import pdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pixel_t                pixel,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output point_t                point,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic enq;
    job_t enq_job;
    job_t head_job;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_VIEW_SELECT: cfg_next.view_select = cfg_data[1:0];
                CFG_VIEW_SIZE:   cfg_next.view_size   = cfg_data[VIEW_W-1:0];
                CFG_FOCAL_X:     cfg_next.focal_x     = cfg_data;
                CFG_FOCAL_Y:     cfg_next.focal_y     = cfg_data;
                CFG_CENTER_X:    cfg_next.center_x    = cfg_data;
                CFG_CENTER_Y:    cfg_next.center_y    = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_select <= RST_VIEW_SELECT;
            cfg_reg.view_size   <= RST_VIEW_SIZE;
            cfg_reg.focal_x     <= RST_FOCAL;
            cfg_reg.focal_y     <= RST_FOCAL;
            cfg_reg.center_x    <= RST_CENTER_X;
            cfg_reg.center_y    <= RST_CENTER_Y;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pdp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pixel  (pixel),
        .full   (full),
        .q_full (q_full),
        .enq    (enq),
        .job    (enq_job)
    );

    pdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (enq),
        .wr_job (enq_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (head_job),
        .empty  (q_empty)
    );

    pdp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .point   (point)
    );

endmodule

### hdl/pdp_checker.sv
// Port-level checks for the depth point projector, bound to the top level.
// Depends on pdp_pkg for the beat types.
`timescale 1ns / 1ps

module pdp_checker
    import pdp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input pixel_t                pixel,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input point_t                point,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // A waiting point holds until popped
    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point)))
        else $error("point changed or vanished while waiting");

    // Jet colors never mix blue and red
    a_jet_no_purple: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((point.blue == '0) || (point.red == '0)))
        else $error("jet color has both blue and red");

    // Jet colors always have one saturated channel
    a_jet_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((point.blue == '1) || (point.green == '1) || (point.red == '1)))
        else $error("jet color has no saturated channel");

endmodule

bind depth_point_projector_jet pdp_checker u_pdp_checker (.*);

### sim/testbench.sv
// Self-checking bench for depth_point_projector_jet: pixel beats in, point beats out.
// Depends on pdp_pkg and the block's RTL; expected points come from an in-bench projector.
`timescale 1ns / 1ps

module testbench;
    import pdp_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    pixel_t                pixel = '0;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    point_t                point;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    depth_point_projector_jet u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pixel     (pixel),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .point     (point),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copy and frame statistics of the projector
    logic [1:0]         sel_r  = RST_VIEW_SELECT;
    logic [VIEW_W-1:0]  size_r = RST_VIEW_SIZE;
    logic [PARAM_W-1:0] fx_r   = RST_FOCAL;
    logic [PARAM_W-1:0] fy_r   = RST_FOCAL;
    logic [PARAM_W-1:0] cx_r   = RST_CENTER_X;
    logic [PARAM_W-1:0] cy_r   = RST_CENTER_Y;
    logic [DEPTH_W-1:0] min_depth = '1;
    logic [DEPTH_W-1:0] max_depth = '0;

    pixel_t pending_pixels[$];
    point_t expected_points[$];
    int     n_queued = 0;
    int     n_taken = 0;
    int     n_points = 0;
    int     n_mismatch = 0;
    int     n_orphan = 0;
    bit     steady = 1'b0;
    int     gap_left = 0;
    int     stall_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint lateral_off(longint pos, longint ctr, longint d, longint v,
                                           longint f, longint s);
        longint num;
        longint den;
        num = (pos * 16 - ctr) * d * v;
        den = 256 * f * s;
        return num / den;
    endfunction

    // Update statistics or project one pixel; returns 1 when a point results
    function automatic bit project_pixel(input pixel_t px, output point_t pt);
        longint v, c, d, zoff, prow, pcol, num, den;
        logic [CHAN_W-1:0] b, g, r;
        pt = '0;
        if (px.func == FUNC_STATS) begin
            if (px.frame_start) begin
                min_depth = px.depth_value;
                max_depth = px.depth_value;
            end else begin
                if (px.depth_value < min_depth) min_depth = px.depth_value;
                if (px.depth_value > max_depth) max_depth = px.depth_value;
            end
            return 1'b0;
        end
        if (px.pixel_col[0] || px.pixel_row[0] || px.depth_value == 0
            || px.depth_value > DEPTH_LIMIT)
            return 1'b0;
        v = size_r;
        c = v / 2;
        d = px.depth_value;
        zoff = d * v / ZDIV;
        case (sel_r)
            VIEW_TOP:
            begin
                if (fx_r == 0) return 1'b0;
                prow = c + zoff;
                pcol = c + lateral_off(px.pixel_col, cx_r, d, v, fx_r, 10);
            end
            VIEW_SIDE:
            begin
                if (fy_r == 0) return 1'b0;
                prow = c - lateral_off(px.pixel_row, cy_r, d, v, fy_r, 10);
                pcol = c + zoff;
            end
            VIEW_FRONT:
            begin
                if (fx_r == 0 || fy_r == 0) return 1'b0;
                prow = c + lateral_off(px.pixel_row, cy_r, d, v, fy_r, 5);
                pcol = c + lateral_off(px.pixel_col, cx_r, d, v, fx_r, 5);
            end
            default: return 1'b0;
        endcase
        if (prow < 0 || prow >= v || pcol < 0 || pcol >= v) return 1'b0;
        // Jet color from the normalized depth
        num = d - longint'(min_depth);
        den = longint'(max_depth) - longint'(min_depth);
        if (den == 0) begin
            b = 0; g = 0; r = 255;
        end else begin
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            if (num < 0) num = 0;
            if (num > den) num = den;
            if (4 * num < den) begin
                r = 0; b = 255; g = CHAN_W'((1020 * num) / den);
            end else if (2 * num < den) begin
                r = 0; g = 255; b = CHAN_W'((255 * (2 * den - 4 * num)) / den);
            end else if (4 * num < 3 * den) begin
                b = 0; g = 255; r = CHAN_W'((255 * (4 * num - 2 * den)) / den);
            end else begin
                b = 0; r = 255; g = CHAN_W'((255 * (4 * den - 4 * num)) / den);
            end
        end
        pt.view_row = VIEW_W'(prow);
        pt.view_col = VIEW_W'(pcol);
        pt.blue = b;
        pt.green = g;
        pt.red = r;
        return 1'b1;
    endfunction

    // Driver: predict on each accepted beat, then present the next one
    always @(posedge clk) begin
        point_t pt;
        if (rst_n) begin
            if (push && !full) begin
                if (project_pixel(pixel, pt))
                    expected_points.insert(expected_points.size(), pt);
                n_taken++;
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    pixel <= pending_pixels.pop_front();
                    push <= 1'b1;
                    gap_left = steady ? 0 : pick_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped point against the oldest expectation
    always @(posedge clk) begin
        point_t exp_pt;
        if (rst_n) begin
            if (pop && !empty) begin
                n_points++;
                if (expected_points.size() == 0) begin
                    n_orphan++;
                    if (n_orphan + n_mismatch <= 10)
                        $display("unexpected point row %0d col %0d", point.view_row,
                                 point.view_col);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (exp_pt != point) begin
                        n_mismatch++;
                        if (n_orphan + n_mismatch <= 10)
                            $display("point mismatch: exp r%0d c%0d bgr %0d/%0d/%0d, got r%0d c%0d bgr %0d/%0d/%0d",
                                     exp_pt.view_row, exp_pt.view_col, exp_pt.blue,
                                     exp_pt.green, exp_pt.red, point.view_row, point.view_col,
                                     point.blue, point.green, point.red);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                stall_left = steady ? 0 : pick_gap();
                pop <= (stall_left == 0);
            end
        end
    end

    task automatic add_pixel(input logic fn, input logic st, input int col, input int row,
                             input int d);
        pixel_t px;
        px.func = fn;
        px.frame_start = st;
        px.pixel_col = COORD_W'(col);
        px.pixel_row = COORD_W'(row);
        px.depth_value = DEPTH_W'(d);
        pending_pixels.insert(pending_pixels.size(), px);
        n_queued++;
    endtask

    // Hold until every beat is taken and every point has come, then let the back end settle
    task automatic drain();
        do @(posedge clk);
        while (n_taken != n_queued || expected_points.size() != 0);
        repeat (1000) @(posedge clk);
    endtask

    task automatic write_regs(input int sel, input int sz, input int fx, input int fy,
                              input int cx, input int cy);
        logic [CFG_IDX_W-1:0] idx[6];
        int val[6];
        idx = '{CFG_VIEW_SELECT, CFG_VIEW_SIZE, CFG_FOCAL_X, CFG_FOCAL_Y,
                CFG_CENTER_X, CFG_CENTER_Y};
        val = '{sel, sz, fx, fy, cx, cy};
        for (int i = 0; i < 6; i++) begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= CFG_DATA_W'(val[i]);
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sel_r = 2'(sel);
        size_r = VIEW_W'(sz);
        fx_r = PARAM_W'(fx);
        fy_r = PARAM_W'(fy);
        cx_r = PARAM_W'(cx);
        cy_r = PARAM_W'(cy);
    endtask

    // Random projection pixel: mostly even and near the principal point, some noise
    task automatic add_random_project();
        int col, row;
        if ($urandom_range(0, 99) < 75) begin
            col = int'(cx_r >> 4) + $urandom_range(0, 400) - 200;
            row = int'(cy_r >> 4) + $urandom_range(0, 400) - 200;
            if (col < 0) col = 0;
            if (row < 0) row = 0;
            if (col > 2046) col = 2046;
            if (row > 2046) row = 2046;
            add_pixel(FUNC_PROJECT, $urandom_range(0, 1), col & ~1, row & ~1,
                      $urandom_range(1, 2560));
        end else begin
            add_pixel(FUNC_PROJECT, $urandom_range(0, 1), $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 65535));
        end
    endtask

    // One frame: statistics pass, half the projection pass, full pause, the rest
    task automatic run_frame(input int n_stats, input int n_proj);
        add_pixel(FUNC_STATS, 1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2560));
        for (int i = 1; i < n_stats; i++)
            add_pixel(FUNC_STATS, $urandom_range(0, 19) == 0, $urandom_range(0, 2047),
                      $urandom_range(0, 2047),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 2560));
        for (int i = 0; i < n_proj / 2; i++) add_random_project();
        drain();
        for (int i = n_proj / 2; i < n_proj; i++) add_random_project();
        drain();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: no statistics yet, so max is below min
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 100);
        add_pixel(FUNC_PROJECT, 1'b1, 320, 240, 2560);
        // Max equals min gives pure red
        add_pixel(FUNC_STATS, 1'b1, 5, 7, 500);
        add_pixel(FUNC_STATS, 1'b0, 2047, 2047, 500);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 500);
        // Statistics span 0 to 10 m, then walk the jet bands
        add_pixel(FUNC_STATS, 1'b1, 0, 0, 0);
        add_pixel(FUNC_STATS, 1'b0, 2047, 0, 2560);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 1);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 640);
        add_pixel(FUNC_PROJECT, 1'b0, 330, 250, 1000);
        add_pixel(FUNC_PROJECT, 1'b0, 300, 220, 1280);
        add_pixel(FUNC_PROJECT, 1'b0, 340, 260, 1700);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 1920);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 2400);
        add_pixel(FUNC_PROJECT, 1'b0, 0, 0, 2560);
        add_pixel(FUNC_PROJECT, 1'b0, 2046, 2046, 1280);
        // Skipped pixels: zero depth, too far, odd column, odd row
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 0);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 2561);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 65535);
        add_pixel(FUNC_PROJECT, 1'b0, 321, 240, 800);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 2047, 800);
        // A far depth widens the statistics
        add_pixel(FUNC_STATS, 1'b0, 1, 1, 65535);
        add_pixel(FUNC_PROJECT, 1'b0, 320, 240, 2000);
        drain();

        // Extremes and special settings, then random settings
        write_regs(VIEW_TOP, 1023, 8400, 8400, 5120, 3840);
        run_frame(40, 80);
        write_regs(VIEW_SIDE, 512, 4000, 6000, 4000, 3000);
        run_frame(40, 80);
        write_regs(VIEW_FRONT, 1, 1, 1, 0, 0);
        run_frame(20, 40);
        write_regs(VIEW_FRONT, 1023, 65535, 65535, 65535, 65535);
        run_frame(40, 80);
        write_regs(3, 700, 8400, 8400, 5120, 3840);
        run_frame(10, 20);
        write_regs(VIEW_FRONT, 0, 8400, 8400, 5120, 3840);
        run_frame(10, 20);
        write_regs(VIEW_FRONT, 700, 0, 8400, 5120, 3840);
        run_frame(10, 20);
        for (int ph = 0; ph < 10; ph++) begin
            steady = (ph % 3 == 2);
            write_regs($urandom_range(0, 2), $urandom_range(1, 1023),
                       $urandom_range(200, 20000), $urandom_range(200, 20000),
                       $urandom_range(0, 16000), $urandom_range(0, 16000));
            run_frame(30, 80);
        end
        steady = 1'b0;

        $display("covered %0d pixel beats over 18 register settings, %0d points checked",
                 n_taken, n_points);
        if (n_mismatch == 0 && n_orphan == 0 && expected_points.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit
    initial begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hdl/pdp_pkg.sv
hdl/pdp_queue.sv
hdl/pdp_front.sv
hdl/pdp_div.sv
hdl/pdp_back.sv
hdl/depth_point_projector_jet.sv
hdl/pdp_checker.sv
sim/testbench.sv
